[hw/rtl/tksbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tksbs_pkg: shared constants for the bright spot tracker
// Field widths, parameter defaults and register reset values.
// ---------------------------------------------------------------------------
package tksbs_pkg;

    localparam int SPOT_COUNT_DEF = 3;
    localparam int COORD_BITS_DEF = 12;

    localparam int PORT_COORD_BITS = 12;
    localparam int VALUE_BITS      = 8;
    localparam int RANK_BITS       = 3;
    localparam int SEP_BITS        = 8;

    localparam logic [SEP_BITS-1:0] SEP_RESET = 8'd10;

    localparam int S_TDATA_BITS = 32;
    localparam int M_TDATA_BITS = 40;

endpackage
`default_nettype wire

[hw/rtl/top_k_separated_bright_spots_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_separated_bright_spots_unit: top-K bright spot tracker
// Keeps the brightest, mutually separated spots of a pixel stream.
// ---------------------------------------------------------------------------
// Pixels enter on the s_ stream, one item per cycle; s_tlast marks the last
// pixel of a frame. Each pixel is held in an input register and, the next
// cycle, checked against every stored spot in parallel and inserted into the
// brightness-sorted table. Ordinary pixels produce no output.
// On a frame's last pixel the updated table is copied to a readout buffer
// and the table is cleared, so the next frame can start in the next cycle.
// The buffer drains SPOT_COUNT items on the m_ stream, brightest first, with
// m_tlast on the final one, from the buffer loaded as the last pixel leaves
// the input register. Sustained rate is one pixel per cycle; a frame's last
// pixel can only leave the input register once the readout buffer is free,
// so frames shorter than SPOT_COUNT pixels, or a stalled receiver, hold
// off s_tready through the single input register.
// min_separation is written on the cfg_ channel (always ready); write it
// only while idle, the block does not enforce this. Reset (aresetn low,
// synchronous) empties the table and buffer and loads min_separation with 10.
// ---------------------------------------------------------------------------
module top_k_separated_bright_spots_unit #(
    parameter int SPOT_COUNT = tksbs_pkg::SPOT_COUNT_DEF,
    parameter int COORD_BITS = tksbs_pkg::COORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration: min_separation
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tksbs_pkg::SEP_BITS-1:0]    cfg_data,
    // pixels, tdata from bit 0: pixel_row[12], pixel_col[12], pixel_value[8]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tksbs_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                              s_tlast,
    // spots, tdata from bit 0: spot_row[12], spot_col[12], spot_brightness[8],
    // spot_rank[3], zero pad[5]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tksbs_pkg::M_TDATA_BITS-1:0]     m_tdata,
    output logic                                   m_tlast
);
    import tksbs_pkg::*;

    localparam int IDX_BITS = (SPOT_COUNT > 1) ? $clog2(SPOT_COUNT) : 1;
    localparam int CMP_BITS = (COORD_BITS > SEP_BITS) ? COORD_BITS : SEP_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SPOT_COUNT - 1);

    // configuration
    logic [SEP_BITS-1:0]   sep_reg;

    // input register
    logic                  in_valid_reg;
    logic                  in_last_reg;
    logic [COORD_BITS-1:0] in_row_reg;
    logic [COORD_BITS-1:0] in_col_reg;
    logic [VALUE_BITS-1:0] in_val_reg;

    // spot table, sorted by descending brightness
    logic [COORD_BITS-1:0] row_reg [SPOT_COUNT];
    logic [COORD_BITS-1:0] col_reg [SPOT_COUNT];
    logic [VALUE_BITS-1:0] val_reg [SPOT_COUNT];
    logic [COORD_BITS-1:0] row_next [SPOT_COUNT];
    logic [COORD_BITS-1:0] col_next [SPOT_COUNT];
    logic [VALUE_BITS-1:0] val_next [SPOT_COUNT];

    // readout buffer
    logic [COORD_BITS-1:0] rd_row_reg [SPOT_COUNT];
    logic [COORD_BITS-1:0] rd_col_reg [SPOT_COUNT];
    logic [VALUE_BITS-1:0] rd_val_reg [SPOT_COUNT];
    logic                  rd_active_reg;
    logic [IDX_BITS-1:0]   rd_idx_reg;

    logic                  rd_free;
    logic                  advance;
    logic                  separate;
    logic                  insert;
    logic [SPOT_COUNT-1:0] ge;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign cfg_ready = 1'b1;

    assign rd_free  = !rd_active_reg || (m_tready && (rd_idx_reg == LAST_IDX));
    assign advance  = in_valid_reg && (!in_last_reg || rd_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        separate = 1'b1;
        for (int i = 0; i < SPOT_COUNT; i++) begin
            if ((val_reg[i] != '0) &&
                (CMP_BITS'(absdiff(row_reg[i], in_row_reg)) <= CMP_BITS'(sep_reg)) &&
                (CMP_BITS'(absdiff(col_reg[i], in_col_reg)) <= CMP_BITS'(sep_reg))) begin
                separate = 1'b0;
            end
        end
        insert = separate && (in_val_reg > val_reg[SPOT_COUNT-1]);
        for (int i = 0; i < SPOT_COUNT; i++) begin
            ge[i] = (val_reg[i] >= in_val_reg);
        end

        // slot 0: take the new spot if it outranks the current top
        row_next[0] = row_reg[0];
        col_next[0] = col_reg[0];
        val_next[0] = val_reg[0];
        if (insert && !ge[0]) begin
            row_next[0] = in_row_reg;
            col_next[0] = in_col_reg;
            val_next[0] = in_val_reg;
        end
        // lower slots: keep, take the new spot, or shift down by one
        for (int i = 1; i < SPOT_COUNT; i++) begin
            row_next[i] = row_reg[i];
            col_next[i] = col_reg[i];
            val_next[i] = val_reg[i];
            if (insert && !ge[i]) begin
                if (ge[i-1]) begin
                    row_next[i] = in_row_reg;
                    col_next[i] = in_col_reg;
                    val_next[i] = in_val_reg;
                end else begin
                    row_next[i] = row_reg[i-1];
                    col_next[i] = col_reg[i-1];
                    val_next[i] = val_reg[i-1];
                end
            end
        end
    end

    // configuration and input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg      <= SEP_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_last_reg <= s_tlast;
            in_row_reg  <= COORD_BITS'(s_tdata[11:0]);
            in_col_reg  <= COORD_BITS'(s_tdata[23:12]);
            in_val_reg  <= s_tdata[31:24];
        end
    end

    // spot table: update per pixel, clear after a frame's last pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SPOT_COUNT; i++) begin
                row_reg[i] <= '0;
                col_reg[i] <= '0;
                val_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < SPOT_COUNT; i++) begin
                if (in_last_reg) begin
                    row_reg[i] <= '0;
                    col_reg[i] <= '0;
                    val_reg[i] <= '0;
                end else begin
                    row_reg[i] <= row_next[i];
                    col_reg[i] <= col_next[i];
                    val_reg[i] <= val_next[i];
                end
            end
        end
    end

    // readout buffer payload
    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            for (int i = 0; i < SPOT_COUNT; i++) begin
                rd_row_reg[i] <= row_next[i];
                rd_col_reg[i] <= col_next[i];
                rd_val_reg[i] <= val_next[i];
            end
        end
    end

    // readout sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_active_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end else if (advance && in_last_reg) begin
            rd_active_reg <= 1'b1;
            rd_idx_reg    <= '0;
        end else if (rd_active_reg && m_tready) begin
            if (rd_idx_reg == LAST_IDX) begin
                rd_active_reg <= 1'b0;
                rd_idx_reg    <= '0;
            end else begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = rd_active_reg;
    assign m_tlast  = (rd_idx_reg == LAST_IDX);
    assign m_tdata  = {5'b0,
                       RANK_BITS'(rd_idx_reg),
                       rd_val_reg[rd_idx_reg],
                       PORT_COORD_BITS'(rd_col_reg[rd_idx_reg]),
                       PORT_COORD_BITS'(rd_row_reg[rd_idx_reg])};

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: bright spot tracker regression
// Streams pixel frames into the tracker, keeps its own sorted spot table and
// compares every spot read out at a frame end, field by field, while both
// stream sides idle and stall at random and min_separation is swept.
// ---------------------------------------------------------------------------
module testbench;

    import tksbs_pkg::*;

    localparam int SPOTS       = SPOT_COUNT_DEF;
    localparam int CB          = PORT_COORD_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [CB-1:0]         row;
        logic [CB-1:0]         col;
        logic [VALUE_BITS-1:0] brightness;
        logic [RANK_BITS-1:0]  rank;
        logic                  last;
    } spot_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [SEP_BITS-1:0]     cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;   // pixel_row[12], pixel_col[12], pixel_value[8]
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;          // spot_row[12], spot_col[12], brightness[8], rank[3]
    logic                    m_tlast;

    top_k_separated_bright_spots_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tracker image: sorted spot table and separation register
    logic [CB-1:0]         table_row [SPOTS];
    logic [CB-1:0]         table_col [SPOTS];
    logic [VALUE_BITS-1:0] table_val [SPOTS];
    logic [SEP_BITS-1:0]   separation = SEP_RESET;
    spot_t                 pending_spots[$];

    int mismatches   = 0;
    int pixels_sent  = 0;
    int frames_sent  = 0;
    int spots_seen   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit tx_idle_en   = 1'b0;
    bit rx_stall_en  = 1'b0;
    int hold_req     = 0;

    initial begin
        for (int i = 0; i < SPOTS; i++) begin
            table_row[i] = '0;
            table_col[i] = '0;
            table_val[i] = '0;
        end
    end

    function automatic logic [CB-1:0] coord_gap(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Update the table with one pixel; on a frame end queue the readout and clear.
    task automatic track_pixel(input bit frame_end, input logic [CB-1:0] r,
                               input logic [CB-1:0] c, input logic [VALUE_BITS-1:0] v);
        bit            clear_of_all;
        spot_t         s;
        logic [CB-1:0] tr, tc;
        logic [VALUE_BITS-1:0] tv;
        clear_of_all = 1'b1;
        for (int i = 0; i < SPOTS; i++) begin
            if (table_val[i] != '0 && coord_gap(table_row[i], r) <= CB'(separation)
                    && coord_gap(table_col[i], c) <= CB'(separation))
                clear_of_all = 1'b0;
        end
        if (clear_of_all && v > table_val[SPOTS-1]) begin
            table_row[SPOTS-1] = r;
            table_col[SPOTS-1] = c;
            table_val[SPOTS-1] = v;
            // bubble up past strictly dimmer spots only
            for (int k = SPOTS - 1; k > 0; k--) begin
                if (table_val[k-1] >= table_val[k])
                    break;
                tr = table_row[k-1]; tc = table_col[k-1]; tv = table_val[k-1];
                table_row[k-1] = table_row[k];
                table_col[k-1] = table_col[k];
                table_val[k-1] = table_val[k];
                table_row[k] = tr; table_col[k] = tc; table_val[k] = tv;
            end
        end
        if (frame_end) begin
            for (int i = 0; i < SPOTS; i++) begin
                s.row        = table_row[i];
                s.col        = table_col[i];
                s.brightness = table_val[i];
                s.rank       = i[RANK_BITS-1:0];
                s.last       = (i == SPOTS - 1);
                pending_spots.push_back(s);
                table_row[i] = '0;
                table_col[i] = '0;
                table_val[i] = '0;
            end
            frames_sent++;
        end
    endtask

    // Offer one pixel; bursts of random length are separated by random gaps.
    task automatic send_pixel(input bit frame_end, input logic [CB-1:0] r,
                              input logic [CB-1:0] c, input logic [VALUE_BITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_idle_en ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {v, c, r};
        s_tlast  <= frame_end;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        track_pixel(frame_end, r, c, v);
    endtask

    // Stop offering, wait for every expected spot, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_spots.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_separation(input logic [SEP_BITS-1:0] sep);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= sep;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        separation = sep;
    endtask

    // Receiver: ready, a rotating stall pattern, or a counted hold-off.
    logic [15:0] rx_pattern = 16'hffff;
    int          rx_hold    = 0;
    int          rx_age     = 0;

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            rx_hold  = hold_req;
            hold_req = 0;
        end
        if (rx_age == 0) begin
            rx_pattern = 16'($urandom);
            rx_age     = $urandom_range(16, 96);
        end
        rx_age--;
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_stall_en) begin
            m_tready <= rx_pattern[0];
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        spot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spots.size() == 0) begin
                $error("unexpected spot item: tdata=%h tlast=%b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_spots.pop_front();
                check_field("spot_row", int'(want.row), int'(m_tdata[CB-1:0]));
                check_field("spot_col", int'(want.col), int'(m_tdata[2*CB-1:CB]));
                check_field("spot_brightness", int'(want.brightness),
                            int'(m_tdata[2*CB+VALUE_BITS-1:2*CB]));
                check_field("spot_rank", int'(want.rank),
                            int'(m_tdata[2*CB+VALUE_BITS+RANK_BITS-1:2*CB+VALUE_BITS]));
                check_field("last_spot", int'(want.last), int'(m_tlast));
                spots_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Corner frames under the reset separation of 10.
    task automatic test_directed();
        // zero brightness, extreme coordinates, equal brightness placement
        send_pixel(1'b0, 12'd0,    12'd0,    8'd0);
        send_pixel(1'b0, 12'd4095, 12'd4095, 8'd255);
        send_pixel(1'b0, 12'd0,    12'd0,    8'd100);
        send_pixel(1'b0, 12'd20,   12'd0,    8'd100);
        // exactly at the separation in both axes: reject
        send_pixel(1'b0, 12'd4085, 12'd4085, 8'd254);
        // one past the separation in rows: accept and move up
        send_pixel(1'b0, 12'd4084, 12'd4085, 8'd254);
        // not strictly brighter than the dimmest spot: drop
        send_pixel(1'b0, 12'd100,  12'd100,  8'd100);
        send_pixel(1'b1, 12'd200,  12'd200,  8'd101);
        // readout of an all-empty table
        send_pixel(1'b1, 12'd300,  12'd300,  8'd0);
        // single spot with two empty slots
        send_pixel(1'b1, 12'd4095, 12'd0,    8'd7);
        // empty slots at the origin must not suppress a pixel there
        send_pixel(1'b1, 12'd0,    12'd0,    8'd50);
        // three ties, a near neighbor and a fourth tie
        send_pixel(1'b0, 12'd50,   12'd50,   8'd80);
        send_pixel(1'b0, 12'd500,  12'd500,  8'd80);
        send_pixel(1'b0, 12'd52,   12'd60,   8'd200);
        send_pixel(1'b0, 12'd900,  12'd900,  8'd80);
        send_pixel(1'b1, 12'd1000, 12'd1000, 8'd80);
        // within range in columns only: accept
        send_pixel(1'b0, 12'd2048, 12'd2048, 8'd90);
        send_pixel(1'b0, 12'd2100, 12'd2050, 8'd95);
        send_pixel(1'b1, 12'd2050, 12'd2100, 8'd170);
        drain();
    endtask

    // Random frames; most pixels cluster so the separation test matters.
    task automatic test_random_frames(input int budget);
        int left, len, span;
        bit clustered;
        logic [CB-1:0] base_r, base_c, r, c;
        logic [VALUE_BITS-1:0] v, prev_v;
        left   = budget;
        prev_v = 8'd128;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            if (len > left)
                len = left;
            clustered = ($urandom_range(0, 3) != 0);
            base_r    = CB'($urandom);
            base_c    = CB'($urandom);
            span      = 3 * int'(separation) + 8;
            for (int i = 0; i < len; i++) begin
                if (clustered) begin
                    r = base_r + CB'($urandom_range(0, span));
                    c = base_c + CB'($urandom_range(0, span));
                end else begin
                    r = CB'($urandom);
                    c = CB'($urandom);
                end
                case ($urandom_range(0, 9))
                    0: v = 8'd0;
                    1: v = 8'd255;
                    2: v = prev_v;
                    default: v = VALUE_BITS'($urandom);
                endcase
                prev_v = v;
                send_pixel(i == len - 1, r, c, v);
            end
            left -= len;
        end
    endtask

    // Hold the receiver off while short frames keep coming, then pause.
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        hold_req    = 300;
        for (int i = 0; i < 12; i++) begin
            send_pixel(1'b0, CB'($urandom), CB'($urandom), VALUE_BITS'($urandom));
            send_pixel(1'b1, CB'($urandom), CB'($urandom), VALUE_BITS'($urandom));
        end
        drain();
    endtask

    task automatic test_separation_sweep();
        logic [SEP_BITS-1:0] seps [6];
        seps = '{8'd0, 8'd255, 8'd1, 8'd10, 8'd254, 8'd0};
        seps[3] = SEP_BITS'($urandom_range(2, 60));
        for (int p = 0; p < 6; p++) begin
            write_separation(seps[p]);
            tx_idle_en  = (p != 2);
            rx_stall_en = (p != 2) && (p != 4);
            test_random_frames(80);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_separation_sweep();
        drain();
        repeat (20) @(posedge aclk);
        $display("Sent %0d pixels in %0d frames; checked %0d spots.",
                 pixels_sent, frames_sent, spots_seen);
        $display("Covered ties, suppression edges, empty slots, stalls and separations 0 to 255.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[top_k_separated_bright_spots_unit.f]
hw/rtl/tksbs_pkg.sv
hw/rtl/top_k_separated_bright_spots_unit.sv
tb/testbench.sv
